@@ rtl/core/emoc_pkg.sv @@
// Shared types and constants of the extent map with overwrite and coalescing.
package emoc_pkg;

  localparam int ENTRIES     = 16;
  localparam int OFFSET_BITS = 48;
  localparam int ADDR_W      = 48;
  localparam int CLIENT_W    = 16;
  localparam int CNT_W       = 5;
  localparam int IDX_W       = $clog2(ENTRIES);
  // piece counter: an add can briefly make ENTRIES + 2 pieces
  localparam int PCW         = $clog2(ENTRIES + 3);

  typedef struct packed {
    logic [ADDR_W-1:0]      s;
    logic [ADDR_W-1:0]      e;
    logic [OFFSET_BITS-1:0] p;
    logic [CLIENT_W-1:0]    c;
  } ext_t;

  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_FIND   = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_DUMP   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_REVERSED = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_TAIL, S_DRAIN, S_FLUSH, S_PAD, S_DONE, S_FIND, S_DUMP, S_RESP
  } state_e;

  // control from the sequencer to the merge stage
  typedef struct packed {
    logic init;
    logic allow;
    logic flush;
  } mctl_t;

endpackage

@@ rtl/core/emoc_cell.sv @@
// One cell of an extent row: shifts from its neighbour or loads in parallel.
module emoc_cell (
  input  logic          clk_i,
  input  logic          shift_en_i,
  input  emoc_pkg::ext_t shift_in_i,
  input  logic          load_en_i,
  input  emoc_pkg::ext_t load_i,
  output emoc_pkg::ext_t val_o
);

  emoc_pkg::ext_t val_q, val_d;

  // parallel load wins over shift
  always_comb begin
    val_d = val_q;
    if (load_en_i) begin
      val_d = load_i;
    end else if (shift_en_i) begin
      val_d = shift_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

@@ rtl/core/emoc_merge.sv @@
// Merge stage: holds the newest piece and joins it with log-contiguous neighbours.
module emoc_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  emoc_pkg::mctl_t   ctl_i,
  input  logic              in_valid_i,
  input  emoc_pkg::ext_t    in_ext_i,
  input  logic              in_new_i,
  output logic              push_o,
  output emoc_pkg::ext_t    push_ext_o,
  output logic [emoc_pkg::PCW-1:0] pieces_o
);

  emoc_pkg::ext_t last_q, last_d;
  logic have_q, have_d;
  logic after_new_q, after_new_d;
  logic [emoc_pkg::PCW-1:0] pieces_q, pieces_d;
  logic [emoc_pkg::ADDR_W:0] end_next;
  logic [emoc_pkg::OFFSET_BITS-1:0] log_next;
  logic joins, merge;

  // held piece ends right before the incoming one, in range and in log
  assign end_next = {1'b0, last_q.e} + {{emoc_pkg::ADDR_W{1'b0}}, 1'b1};
  assign log_next = last_q.p + emoc_pkg::OFFSET_BITS'(last_q.e - last_q.s)
                  + {{(emoc_pkg::OFFSET_BITS-1){1'b0}}, 1'b1};
  assign joins = have_q && (end_next == {1'b0, in_ext_i.s}) && (log_next == in_ext_i.p);
  // only the new extent joins its lower neighbour, then its upper one
  assign merge = ctl_i.allow && joins && (in_new_i || after_new_q);

  always_comb begin
    last_d      = last_q;
    have_d      = have_q;
    after_new_d = after_new_q;
    pieces_d    = pieces_q;
    push_o      = 1'b0;
    if (ctl_i.init) begin
      have_d      = 1'b0;
      after_new_d = 1'b0;
      pieces_d    = '0;
    end else if (in_valid_i) begin
      if (merge) begin
        last_d.e    = in_ext_i.e;
        after_new_d = in_new_i;
      end else begin
        push_o      = have_q;
        last_d      = in_ext_i;
        have_d      = 1'b1;
        after_new_d = in_new_i;
        pieces_d    = pieces_q + 1'b1;
      end
    end else if (ctl_i.flush) begin
      push_o = have_q;
      have_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      after_new_q <= 1'b0;
      pieces_q    <= '0;
    end else begin
      have_q      <= have_d;
      after_new_q <= after_new_d;
      pieces_q    <= pieces_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
  end

  assign push_ext_o = last_q;
  assign pieces_o   = pieces_q;

endmodule

@@ rtl/core/extent_map_overwrite_coalesce.sv @@
// Top level of the extent map: cell rows, sequencer and result register.
//
//  channel  | dir | tdata                                    | tuser / tlast
//  s_axis   | in  | range_start, range_end, log_offset, client | kind / -
//  m_axis   | out | ext_*, extent_count, max_end             | found, status / last
//
// Add and remove rotate the table one cell per three-phase step, then pad the
// scratch row up to ENTRIES pieces. Find rotates the table through every cell,
// dump steps through every cell one per cycle, holding on a live cell while the
// output stalls, and clear zeroes the count and largest end.
// Reset clears the count and largest end; cell contents are not reset.
// One word is worked on at a time; a waiting result does not block acceptance.
module extent_map_overwrite_coalesce (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // range_start[47:0], range_end[95:48], log_offset[143:96], client[159:144]
  input  logic [159:0] s_axis_tdata,
  // kind[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // ext_start[47:0], ext_end[95:48], ext_log_offset[143:96], ext_client[159:144],
  // extent_count[164:160], max_end[212:165], zero pad [215:213]
  output logic [215:0] m_axis_tdata,
  // found[0], status[2:1]
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam int N = emoc_pkg::ENTRIES;

  emoc_pkg::state_e state_q, state_d;
  emoc_pkg::kind_e  kind_q, kind_d;
  emoc_pkg::ext_t   req_q, req_d;
  logic [emoc_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [1:0] ph_q, ph_d;
  logic ins_q, ins_d;
  logic [emoc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [emoc_pkg::ADDR_W-1:0] largest_q, largest_d;
  logic [emoc_pkg::PCW-1:0] sh_q, sh_d;
  logic hit_q, hit_d;
  emoc_pkg::ext_t hit_ext_q, hit_ext_d;
  emoc_pkg::status_e stat_q, stat_d;
  logic pend_v_q, pend_v_d, pend_new_q, pend_new_d;
  emoc_pkg::ext_t pend_q, pend_d;

  logic out_v_q;
  logic out_found_q, out_last_q;
  emoc_pkg::ext_t out_ext_q;
  emoc_pkg::status_e out_stat_q;
  logic [emoc_pkg::CNT_W-1:0] out_cnt_q;
  logic [emoc_pkg::ADDR_W-1:0] out_max_q;
  logic out_we, ow_found, ow_last;
  emoc_pkg::ext_t ow_ext;
  emoc_pkg::status_e ow_stat;

  logic accept, out_free, st_rot, commit, sc_shift;
  emoc_pkg::mctl_t mctl;
  logic push;
  emoc_pkg::ext_t push_ext;
  logic [emoc_pkg::PCW-1:0] pieces;

  emoc_pkg::ext_t st_cell [N];
  emoc_pkg::ext_t sc_cell [N];
  emoc_pkg::ext_t in_ext, head;
  logic in_rev, live, below, above, last_step;

  assign in_ext.s = s_axis_tdata[47:0];
  assign in_ext.e = s_axis_tdata[95:48];
  assign in_ext.p = s_axis_tdata[143:96];
  assign in_ext.c = s_axis_tdata[159:144];
  assign in_rev   = in_ext.s > in_ext.e;

  assign s_axis_tready = (state_q == emoc_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_v_q || m_axis_tready;

  // table row rotates through cell 0; scratch row fills from the top
  assign head = st_cell[0];
  for (genvar k = 0; k < N; k++) begin : g_row
    emoc_cell u_st (
      .clk_i      (clk_i),
      .shift_en_i (st_rot),
      .shift_in_i (st_cell[(k + 1) % N]),
      .load_en_i  (commit),
      .load_i     (sc_cell[k]),
      .val_o      (st_cell[k])
    );
    emoc_cell u_sc (
      .clk_i      (clk_i),
      .shift_en_i (sc_shift),
      .shift_in_i ((k == N - 1) ? push_ext : sc_cell[(k + 1) % N]),
      .load_en_i  (1'b0),
      .load_i     (push_ext),
      .val_o      (sc_cell[k])
    );
  end

  assign mctl.init  = accept;
  assign mctl.allow = (kind_q == emoc_pkg::KIND_ADD);
  assign mctl.flush = (state_q == emoc_pkg::S_FLUSH);

  emoc_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mctl),
    .in_valid_i (pend_v_q),
    .in_ext_i   (pend_q),
    .in_new_i   (pend_new_q),
    .push_o     (push),
    .push_ext_o (push_ext),
    .pieces_o   (pieces)
  );

  assign sc_shift = push ||
                    ((state_q == emoc_pkg::S_PAD) && (sh_q < emoc_pkg::PCW'(N)));

  // position of the head cell against the requested range
  assign live      = emoc_pkg::CNT_W'(idx_q) < cnt_q;
  assign below     = head.e < req_q.s;
  assign above     = head.s > req_q.e;
  assign last_step = (idx_q == emoc_pkg::IDX_W'(N - 1));

  // sequencer
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    req_d      = req_q;
    idx_d      = idx_q;
    ph_d       = ph_q;
    ins_d      = ins_q;
    cnt_d      = cnt_q;
    largest_d  = largest_q;
    sh_d       = sh_q + emoc_pkg::PCW'(sc_shift);
    hit_d      = hit_q;
    hit_ext_d  = hit_ext_q;
    stat_d     = stat_q;
    pend_v_d   = 1'b0;
    pend_d     = pend_q;
    pend_new_d = 1'b0;
    st_rot     = 1'b0;
    commit     = 1'b0;
    out_we     = 1'b0;
    ow_found   = 1'b0;
    ow_ext     = '0;
    ow_stat    = emoc_pkg::ST_OK;
    ow_last    = 1'b1;
    unique case (state_q)
      emoc_pkg::S_IDLE: begin
        if (accept) begin
          kind_d    = emoc_pkg::kind_e'(s_axis_tuser);
          req_d     = in_ext;
          idx_d     = '0;
          ph_d      = '0;
          sh_d      = '0;
          hit_d     = 1'b0;
          hit_ext_d = '0;
          stat_d    = emoc_pkg::ST_OK;
          state_d   = emoc_pkg::S_RESP;
          case (s_axis_tuser) inside
            emoc_pkg::KIND_ADD, emoc_pkg::KIND_REMOVE: begin
              if (in_rev) begin
                stat_d = emoc_pkg::ST_REVERSED;
              end else begin
                ins_d   = (s_axis_tuser == emoc_pkg::KIND_REMOVE);
                state_d = emoc_pkg::S_SCAN;
              end
            end
            emoc_pkg::KIND_FIND: begin
              if (in_rev) begin
                stat_d = emoc_pkg::ST_REVERSED;
              end else begin
                state_d = emoc_pkg::S_FIND;
              end
            end
            emoc_pkg::KIND_CLEAR: begin
              cnt_d     = '0;
              largest_d = '0;
            end
            emoc_pkg::KIND_DUMP: begin
              if (cnt_q != '0) begin
                state_d = emoc_pkg::S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      emoc_pkg::S_SCAN: begin
        case (ph_q)
          2'd0: begin
            // lower fragment of an overlapped extent
            if (live && !below && !above && (head.s < req_q.s)) begin
              pend_v_d = 1'b1;
              pend_d   = head;
              pend_d.e = req_q.s - 1'b1;
            end
            ph_d = 2'd1;
          end
          2'd1: begin
            // new extent goes in before the first extent reaching past it
            if (live && !ins_q && (above || (!below && (head.e > req_q.e)))) begin
              pend_v_d   = 1'b1;
              pend_d     = req_q;
              pend_new_d = 1'b1;
              ins_d      = 1'b1;
            end
            ph_d = 2'd2;
          end
          default: begin
            // untouched extent, or upper fragment with shifted log offset
            if (live) begin
              if (below || above) begin
                pend_v_d = 1'b1;
                pend_d   = head;
              end else if (head.e > req_q.e) begin
                pend_v_d = 1'b1;
                pend_d   = head;
                pend_d.s = req_q.e + 1'b1;
                pend_d.p = head.p + emoc_pkg::OFFSET_BITS'(req_q.e + 1'b1 - head.s);
              end
            end
            st_rot = 1'b1;
            idx_d  = idx_q + 1'b1;
            ph_d   = 2'd0;
            if (last_step) begin
              state_d = emoc_pkg::S_TAIL;
            end
          end
        endcase
      end
      emoc_pkg::S_TAIL: begin
        if (!ins_q) begin
          pend_v_d   = 1'b1;
          pend_d     = req_q;
          pend_new_d = 1'b1;
          ins_d      = 1'b1;
        end
        state_d = emoc_pkg::S_DRAIN;
      end
      emoc_pkg::S_DRAIN: begin
        state_d = emoc_pkg::S_FLUSH;
      end
      emoc_pkg::S_FLUSH: begin
        state_d = emoc_pkg::S_PAD;
      end
      emoc_pkg::S_PAD: begin
        if (sh_q >= emoc_pkg::PCW'(N)) begin
          state_d = emoc_pkg::S_DONE;
        end
      end
      emoc_pkg::S_DONE: begin
        if (pieces > emoc_pkg::PCW'(N)) begin
          stat_d = emoc_pkg::ST_FULL;
        end else begin
          commit = 1'b1;
          cnt_d  = emoc_pkg::CNT_W'(pieces);
          if ((kind_q == emoc_pkg::KIND_ADD) && (req_q.e > largest_q)) begin
            largest_d = req_q.e;
          end
        end
        state_d = emoc_pkg::S_RESP;
      end
      emoc_pkg::S_FIND: begin
        if (!hit_q && live && !below && !above) begin
          hit_d     = 1'b1;
          hit_ext_d = head;
        end
        st_rot = 1'b1;
        idx_d  = idx_q + 1'b1;
        if (last_step) begin
          state_d = emoc_pkg::S_RESP;
        end
      end
      emoc_pkg::S_DUMP: begin
        if (!live || out_free) begin
          if (live) begin
            out_we   = 1'b1;
            ow_found = 1'b1;
            ow_ext   = head;
            ow_last  = (emoc_pkg::CNT_W'(idx_q) + 1'b1 == cnt_q);
          end
          st_rot = 1'b1;
          idx_d  = idx_q + 1'b1;
          if (last_step) begin
            state_d = emoc_pkg::S_IDLE;
          end
        end
      end
      emoc_pkg::S_RESP: begin
        if (out_free) begin
          out_we   = 1'b1;
          ow_found = hit_q;
          ow_ext   = hit_ext_q;
          ow_stat  = stat_q;
          state_d  = emoc_pkg::S_IDLE;
        end
      end
      default: state_d = emoc_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= emoc_pkg::S_IDLE;
      cnt_q     <= '0;
      largest_q <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      idx_q     <= '0;
      ph_q      <= '0;
      sh_q      <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      largest_q <= largest_d;
      pend_v_q  <= pend_v_d;
      idx_q     <= idx_d;
      ph_q      <= ph_d;
      sh_q      <= sh_d;
      if (out_we) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    req_q      <= req_d;
    ins_q      <= ins_d;
    hit_q      <= hit_d;
    hit_ext_q  <= hit_ext_d;
    stat_q     <= stat_d;
    pend_q     <= pend_d;
    pend_new_q <= pend_new_d;
    if (out_we) begin
      out_found_q <= ow_found;
      out_ext_q   <= ow_ext;
      out_stat_q  <= ow_stat;
      out_last_q  <= ow_last;
      out_cnt_q   <= cnt_q;
      out_max_q   <= largest_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'b000, out_max_q, out_cnt_q, out_ext_q.c, out_ext_q.p,
                          out_ext_q.e, out_ext_q.s};
  assign m_axis_tuser  = {out_stat_q, out_found_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= emoc_pkg::CNT_W'(N))
    else $error("extent count beyond table depth");
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("input taken while busy");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[159:0] == '0))
    else $error("extent fields not zero on a miss");
`endif

endmodule
